/* sv/peu_pkg.sv */
package peu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned AGE_W  = 24;
    localparam int unsigned LIFE_W = 17;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned RAD_W  = 21;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned DRAW_W = 6;
    localparam int unsigned FRAC_W = 16;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_GRAVITY    = 3'd0,
        REG_RADIUS     = 3'd1,
        REG_BOX_X_LOW  = 3'd2,
        REG_BOX_X_HIGH = 3'd3,
        REG_BOX_Y_LOW  = 3'd4,
        REG_BOX_Y_HIGH = 3'd5
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_GRAVITY    = 24'hF60000;   // -10.0
    localparam logic [RAD_W-1:0] RST_RADIUS     = 21'd19661;    // 0.3
    localparam logic [CFG_W-1:0] RST_BOX_X_LOW  = 24'hF10000;   // -15.0
    localparam logic [CFG_W-1:0] RST_BOX_X_HIGH = 24'h0F0000;   // 15.0
    localparam logic [CFG_W-1:0] RST_BOX_Y_LOW  = 24'hF10000;
    localparam logic [CFG_W-1:0] RST_BOX_Y_HIGH = 24'h0F0000;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    // One table row: one particle
    typedef struct packed {
        logic [2:0][DATA_W-1:0] pos;
        logic [2:0][DATA_W-1:0] vel;
        logic [AGE_W-1:0]       age;
        logic [LIFE_W-1:0]      life;
        logic                   hue;
    } t_row;

    // 1.0 + 0.1 * tenths in unsigned Q1.16, rounded to nearest; saturates above nine
    function automatic logic [LIFE_W-1:0] life_of(input logic [3:0] tenths);
        logic [LIFE_W-1:0] l;
        case (tenths)
            4'd0:    l = 17'd65536;
            4'd1:    l = 17'd72090;
            4'd2:    l = 17'd78643;
            4'd3:    l = 17'd85197;
            4'd4:    l = 17'd91750;
            4'd5:    l = 17'd98304;
            4'd6:    l = 17'd104858;
            4'd7:    l = 17'd111411;
            4'd8:    l = 17'd117965;
            4'd9:    l = 17'd124518;
            default: l = 17'd131071;
        endcase
        return l;
    endfunction

    // Draw reduced mod 30; draw is below 64
    function automatic logic [4:0] mod30(input logic [DRAW_W-1:0] d);
        logic [DRAW_W-1:0] r;
        if (d >= 6'd60) begin
            r = d - 6'd60;
        end else if (d >= 6'd30) begin
            r = d - 6'd30;
        end else begin
            r = d;
        end
        return r[4:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic [DATA_W:0] v);
        logic [DATA_W-1:0] r;
        if (v[DATA_W] == v[DATA_W-1]) begin
            r = v[DATA_W-1:0];
        end else if (v[DATA_W]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] neg_sat(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v == S32_MIN) begin
            r = S32_MAX;
        end else begin
            r = (~v) + 32'd1;
        end
        return r;
    endfunction

endpackage

/* sv/particle_euler_update.sv */
// Particle table with Euler integration and wall bounce, Q16.16 fixed point.
//
// Input channel (i_valid / o_ready): one word per item. func 0 loads a slot
// with a fresh particle, func 1 steps the particle in that slot by dt.
// Output channel (o_valid / i_ready): one result word per item, holding the
// slot, the new position, age, life, hue and a respawn flag.
// Configuration: APB-style port, six registers at byte addresses 0..20
// (gravity, radius, box walls); write only while no item is in flight.
// Flow: o_ready is high only while idle; it returns high when the result of
// the accepted item is registered. The stages are set by the single-ported
// particle row memory: read, select, multiply by dt, add, wall test with
// write-back, one stage each, with one item in the loop at a time so the
// next read always sees the last write.
// The result sits in an output register; a new item is taken while it waits.
// When the receiver stalls, the next item runs up to the wall stage and
// holds there until the output register frees up.
// Reset: control state and configuration registers return to defaults.
// Table contents are not cleared; a slot must be loaded before it is stepped.
// Slots at or above PARTICLE_COUNT leave the table untouched and compute
// from an all-zero particle.
module particle_euler_update #(
    parameter int unsigned PARTICLE_COUNT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input word
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [9:0]  i_slot,
    input  logic [15:0] i_time_delta,
    input  logic signed [31:0] i_emit_x,
    input  logic signed [31:0] i_emit_y,
    input  logic [5:0]  i_draw_a,
    input  logic [5:0]  i_draw_b,
    input  logic [5:0]  i_draw_c,
    input  logic [3:0]  i_life_tenths,
    input  logic        i_hue_pick,
    // result word
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_slot_out,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [23:0] o_age_out,
    output logic [16:0] o_life_out,
    output logic        o_hue_out,
    output logic        o_respawned
);

    localparam int unsigned AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_SEL  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_WALL = 6'b100000
    } t_state;

    // Captured input word
    typedef struct packed {
        logic        func;
        logic [9:0]  slot;
        logic [15:0] dt;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [5:0]  da;
        logic [5:0]  db;
        logic [5:0]  dc;
        logic [3:0]  tenths;
        logic        hue;
    } t_in;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [23:0] r_gravity;
    logic [20:0] r_radius;
    logic [23:0] r_box_xl;
    logic [23:0] r_box_xh;
    logic [23:0] r_box_yl;
    logic [23:0] r_box_yh;
    logic        w_cfg_wr;
    peu_pkg::t_reg_idx w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = peu_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= peu_pkg::RST_GRAVITY;
            r_radius  <= peu_pkg::RST_RADIUS;
            r_box_xl  <= peu_pkg::RST_BOX_X_LOW;
            r_box_xh  <= peu_pkg::RST_BOX_X_HIGH;
            r_box_yl  <= peu_pkg::RST_BOX_Y_LOW;
            r_box_yh  <= peu_pkg::RST_BOX_Y_HIGH;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                peu_pkg::REG_GRAVITY:    r_gravity <= pwdata[23:0];
                peu_pkg::REG_RADIUS:     r_radius  <= pwdata[20:0];
                peu_pkg::REG_BOX_X_LOW:  r_box_xl  <= pwdata[23:0];
                peu_pkg::REG_BOX_X_HIGH: r_box_xh  <= pwdata[23:0];
                peu_pkg::REG_BOX_Y_LOW:  r_box_yl  <= pwdata[23:0];
                peu_pkg::REG_BOX_Y_HIGH: r_box_yh  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read back, signed registers sign-extended
    always_comb begin
        case (w_reg_idx)
            peu_pkg::REG_GRAVITY:    prdata = {{8{r_gravity[23]}}, r_gravity};
            peu_pkg::REG_RADIUS:     prdata = {11'd0, r_radius};
            peu_pkg::REG_BOX_X_LOW:  prdata = {{8{r_box_xl[23]}}, r_box_xl};
            peu_pkg::REG_BOX_X_HIGH: prdata = {{8{r_box_xh[23]}}, r_box_xh};
            peu_pkg::REG_BOX_Y_LOW:  prdata = {{8{r_box_yl[23]}}, r_box_yl};
            peu_pkg::REG_BOX_Y_HIGH: prdata = {{8{r_box_yh[23]}}, r_box_yh};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    t_state         r_state;
    t_state         n_state;
    t_in            r_in;
    logic           r_slot_ok;
    logic [AW-1:0]  r_idx;
    logic [AW+9:0]  w_slot_wide;
    logic           w_accept;
    logic           w_wall_done;
    logic           r_out_valid;

    assign o_ready     = (r_state == ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_wall_done = (r_state == ST_WALL) && (!r_out_valid || i_ready);
    assign w_slot_wide = (AW+10)'(i_slot);

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_valid ? ST_READ : ST_IDLE;
            ST_READ: n_state = ST_SEL;
            ST_SEL:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_WALL;
            ST_WALL: n_state = w_wall_done ? ST_IDLE : ST_WALL;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the input word; slots past the table never write to memory
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.func   <= i_func;
            r_in.slot   <= i_slot;
            r_in.dt     <= i_time_delta;
            r_in.ex     <= i_emit_x;
            r_in.ey     <= i_emit_y;
            r_in.da     <= i_draw_a;
            r_in.db     <= i_draw_b;
            r_in.dc     <= i_draw_c;
            r_in.tenths <= i_life_tenths;
            r_in.hue    <= i_hue_pick;
            r_slot_ok   <= (32'(i_slot) < PARTICLE_COUNT);
            r_idx       <= w_slot_wide[AW-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Particle row memory: one row per particle, registered read
    // ---------------------------------------------------------------------
    peu_pkg::t_row r_mem [PARTICLE_COUNT];
    peu_pkg::t_row r_rd_row;
    peu_pkg::t_row w_wr_row;
    logic          w_mem_we;

    assign w_mem_we = w_wall_done && r_slot_ok;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_wr_row;
        end
        r_rd_row <= r_mem[r_idx];
    end

    // ---------------------------------------------------------------------
    // Datapath working registers
    // ---------------------------------------------------------------------
    logic [2:0][31:0] r_pos, n_pos;
    logic [2:0][31:0] r_vel, n_vel;
    logic [23:0]      r_age, n_age;
    logic [16:0]      r_life, n_life;
    logic             r_hue, n_hue;
    logic             r_resp, n_resp;
    logic [2:0][31:0] r_prod;
    logic [23:0]      r_gprod;

    // Select stage: age, lifetime check, respawn or load
    peu_pkg::t_row    w_base;
    logic [24:0]      w_age_sum;
    logic [23:0]      w_age_sat;
    logic             w_expire;
    logic [2:0][31:0] w_spawn_vel;
    logic [2:0][31:0] w_load_vel;
    logic [2:0][5:0]  w_draw;
    logic signed [15:0] w_spawn_int [3];
    logic signed [15:0] w_load_int [3];

    assign w_base    = r_slot_ok ? r_rd_row : '0;
    assign w_age_sum = {1'b0, w_base.age} + 25'(r_in.dt);
    assign w_age_sat = w_age_sum[24] ? 24'hFF_FFFF : w_age_sum[23:0];
    assign w_expire  = w_age_sat > 24'(w_base.life);
    assign w_draw    = {r_in.dc, r_in.db, r_in.da};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // Y spawns with offset 11, X and Z with 15
            w_spawn_int[k] = $signed({11'd0, peu_pkg::mod30(w_draw[k])})
                             - ((k == 1) ? 16'sd11 : 16'sd15);
            w_load_int[k]  = $signed({10'd0, w_draw[k]}) - 16'sd26;
            w_spawn_vel[k] = {w_spawn_int[k], 16'h0000};
            w_load_vel[k]  = {w_load_int[k], 16'h0000};
        end
    end

    // Multiply stage: floor((v * dt) / 2^16) is the arithmetic shift
    logic signed [48:0] w_mul [3];
    logic signed [40:0] w_gmul;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mul[k] = $signed(r_vel[k]) * $signed({1'b0, r_in.dt});
        end
    end
    assign w_gmul = $signed(r_gravity) * $signed({1'b0, r_in.dt});

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= w_mul[k][47:16];
            end
            r_gprod <= w_gmul[39:16];
        end
    end

    // Add stage sums
    logic [2:0][32:0] w_pos_sum;
    logic [32:0]      w_vy_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pos_sum[k] = {r_pos[k][31], r_pos[k]} + {r_prod[k][31], r_prod[k]};
        end
    end
    assign w_vy_sum = {r_vel[1][31], r_vel[1]} + {{9{r_gprod[23]}}, r_gprod};

    always_comb begin
        n_pos  = r_pos;
        n_vel  = r_vel;
        n_age  = r_age;
        n_life = r_life;
        n_hue  = r_hue;
        n_resp = r_resp;
        case (r_state)
            ST_SEL: begin
                if (r_in.func == peu_pkg::FUNC_LOAD) begin
                    n_pos  = '0;
                    n_vel  = w_load_vel;
                    n_age  = '0;
                    n_life = peu_pkg::life_of(r_in.tenths);
                    n_hue  = r_in.hue;
                    n_resp = 1'b0;
                end else if (w_expire) begin
                    n_pos  = {32'd0, r_in.ey, r_in.ex};
                    n_vel  = w_spawn_vel;
                    n_age  = '0;
                    n_life = w_base.life;
                    n_hue  = w_base.hue;
                    n_resp = 1'b1;
                end else begin
                    n_pos  = w_base.pos;
                    n_vel  = w_base.vel;
                    n_age  = w_age_sat;
                    n_life = w_base.life;
                    n_hue  = w_base.hue;
                    n_resp = 1'b0;
                end
            end
            ST_ADD: begin
                // Positions advance with the old velocity; gravity on Y only
                if (r_in.func == peu_pkg::FUNC_STEP) begin
                    for (int k = 0; k < 3; k++) begin
                        n_pos[k] = peu_pkg::sat32(w_pos_sum[k]);
                    end
                    n_vel[1] = peu_pkg::sat32(w_vy_sum);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_vel  <= n_vel;
        r_age  <= n_age;
        r_life <= n_life;
        r_hue  <= n_hue;
        r_resp <= n_resp;
    end

    // Wall stage: sphere against the box, exact in 34 bits
    logic signed [33:0] w_x_lo, w_x_hi, w_y_lo, w_y_hi;
    logic signed [33:0] w_bxl, w_bxh, w_byl, w_byh;
    logic signed [33:0] w_px, w_py, w_rad;
    logic               w_hit_x, w_hit_y;
    logic [2:0][31:0]   w_vel_out;

    assign w_px  = {{2{r_pos[0][31]}}, r_pos[0]};
    assign w_py  = {{2{r_pos[1][31]}}, r_pos[1]};
    assign w_rad = {13'd0, r_radius};
    assign w_bxl = {{10{r_box_xl[23]}}, r_box_xl};
    assign w_bxh = {{10{r_box_xh[23]}}, r_box_xh};
    assign w_byl = {{10{r_box_yl[23]}}, r_box_yl};
    assign w_byh = {{10{r_box_yh[23]}}, r_box_yh};

    assign w_x_lo = w_px - w_rad;
    assign w_x_hi = w_px + w_rad;
    assign w_y_lo = w_py - w_rad;
    assign w_y_hi = w_py + w_rad;

    assign w_hit_x = (r_in.func == peu_pkg::FUNC_STEP) && ((w_x_lo < w_bxl) || (w_x_hi > w_bxh));
    assign w_hit_y = (r_in.func == peu_pkg::FUNC_STEP) && ((w_y_lo < w_byl) || (w_y_hi > w_byh));

    always_comb begin
        w_vel_out    = r_vel;
        w_vel_out[0] = w_hit_x ? peu_pkg::neg_sat(r_vel[0]) : r_vel[0];
        w_vel_out[1] = w_hit_y ? peu_pkg::neg_sat(r_vel[1]) : r_vel[1];
    end

    assign w_wr_row.pos  = r_pos;
    assign w_wr_row.vel  = w_vel_out;
    assign w_wr_row.age  = r_age;
    assign w_wr_row.life = r_life;
    assign w_wr_row.hue  = r_hue;

    // ---------------------------------------------------------------------
    // Output register: hold the word until the receiver takes it
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wall_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wall_done) begin
            o_slot_out  <= r_in.slot;
            o_pos_x     <= r_pos[0];
            o_pos_y     <= r_pos[1];
            o_pos_z     <= r_pos[2];
            o_age_out   <= r_age;
            o_life_out  <= r_life;
            o_hue_out   <= r_hue;
            o_respawned <= r_resp;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* sv/peu_chk.sv */
module peu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [9:0]  o_slot_out,
    input logic [23:0] o_age_out,
    input logic        o_respawned,
    input logic        pready
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_slot_out)))
        else $error("result word changed while stalled");

    // One item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken twice in a row");

    // No result can appear right after an accept while none is waiting
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> !o_valid)
        else $error("result appeared too early");

    // A respawned particle restarts its age
    a_resp_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_respawned) |-> (o_age_out == 24'd0))
        else $error("respawn with nonzero age");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind particle_euler_update peu_chk u_peu_chk (.*);

/* sim/particle_euler_update_test.sv */
module particle_euler_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS         = 1024;
    localparam int unsigned RANDOM_WORDS  = 1650;
    localparam int unsigned PHASES        = 6;
    // Hard limit; allows for every word's passage, gaps, stalls and drains many times over.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Pipeline depth plus margin; used before register writes and at the end
    localparam int unsigned SETTLE_CYCLES = 12;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint AGE_MAX = 64'sd16777215;
    localparam longint LIFE_MAX = 64'sd131071;
    localparam longint ONE_Q16 = 64'sd65536;

    // One input word, field by field
    typedef struct {
        logic        func;
        logic [9:0]  slot;
        logic [15:0] dt;
        logic [31:0] emit_x;
        logic [31:0] emit_y;
        logic [5:0]  draw_a;
        logic [5:0]  draw_b;
        logic [5:0]  draw_c;
        logic [3:0]  tenths;
        logic        hue;
    } t_particle_cmd;

    // One result word, field by field
    typedef struct {
        logic [9:0]  slot;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [23:0] age;
        logic [16:0] life;
        logic        hue;
        logic        respawned;
    } t_particle_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [9:0]  i_slot = '0;
    logic [15:0] i_time_delta = '0;
    logic signed [31:0] i_emit_x = '0;
    logic signed [31:0] i_emit_y = '0;
    logic [5:0]  i_draw_a = '0;
    logic [5:0]  i_draw_b = '0;
    logic [5:0]  i_draw_c = '0;
    logic [3:0]  i_life_tenths = '0;
    logic        i_hue_pick = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_slot_out;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic [23:0] o_age_out;
    logic [16:0] o_life_out;
    logic        o_hue_out;
    logic        o_respawned;

    // Shadow of the particle table, kept in step with every accepted word
    logic signed [31:0] pos_mem [SLOTS][3];
    logic signed [31:0] vel_mem [SLOTS][3];
    logic [23:0]        age_mem [SLOTS];
    logic [16:0]        life_mem [SLOTS];
    logic               hue_mem [SLOTS];
    bit                 slot_loaded [SLOTS];
    int unsigned        loaded_slots [$];
    int unsigned        recent_slots [$];

    // Shadow of the configuration registers
    longint gravity_q;
    longint radius_q;
    longint x_low_q;
    longint x_high_q;
    longint y_low_q;
    longint y_high_q;

    t_particle_state pending_states [$];
    t_particle_state oldest;
    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;
    // Set for a stretch with no idling on either side
    bit              steady = 1'b0;

    particle_euler_update u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_time_delta  (i_time_delta),
        .i_emit_x      (i_emit_x),
        .i_emit_y      (i_emit_y),
        .i_draw_a      (i_draw_a),
        .i_draw_b      (i_draw_b),
        .i_draw_c      (i_draw_c),
        .i_life_tenths (i_life_tenths),
        .i_hue_pick    (i_hue_pick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot_out    (o_slot_out),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_age_out     (o_age_out),
        .o_life_out    (o_life_out),
        .o_hue_out     (o_hue_out),
        .o_respawned   (o_respawned)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp to the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > POS_MAX) begin
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            return POS_MIN;
        end
        return v;
    endfunction

    // (a * dt) >> 16; the arithmetic shift rounds toward minus infinity
    function automatic longint scale_by_dt(input longint a, input logic [15:0] dt);
        return (a * longint'({1'b0, dt})) >>> 16;
    endfunction

    // Apply one word to the shadow table and return the result word it causes.
    // Only loaded slots are ever stepped, and the slot field cannot exceed the
    // table, so the out-of-table path never arises here.
    function automatic t_particle_state advance_particle(input t_particle_cmd c);
        t_particle_state r;
        longint p [3];
        longint v [3];
        longint age_n;
        longint life_n;
        logic   h;
        bit     resp;
        int     s;
        int     da;
        int     db;
        int     dc;

        s = int'(c.slot);
        resp = 1'b0;
        if (c.func == peu_pkg::FUNC_LOAD) begin
            // Life is 1.0 + 0.1 * tenths, rounded to nearest, capped at the field
            life_n = ONE_Q16 + (longint'(c.tenths) * ONE_Q16 + 5) / 10;
            if (life_n > LIFE_MAX) begin
                life_n = LIFE_MAX;
            end
            for (int k = 0; k < 3; k++) begin
                p[k] = 0;
            end
            v[0] = (longint'(c.draw_a) - 26) * ONE_Q16;
            v[1] = (longint'(c.draw_b) - 26) * ONE_Q16;
            v[2] = (longint'(c.draw_c) - 26) * ONE_Q16;
            age_n = 0;
            h = c.hue;
        end else begin
            for (int k = 0; k < 3; k++) begin
                p[k] = pos_mem[s][k];
                v[k] = vel_mem[s][k];
            end
            life_n = longint'(life_mem[s]);
            h = hue_mem[s];
            age_n = longint'(age_mem[s]) + longint'({1'b0, c.dt});
            if (age_n > AGE_MAX) begin
                age_n = AGE_MAX;
            end
            // Respawn only when age strictly exceeds life
            if (age_n > life_n) begin
                da = int'(c.draw_a) % 30;
                db = int'(c.draw_b) % 30;
                dc = int'(c.draw_c) % 30;
                p[0] = longint'($signed(c.emit_x));
                p[1] = longint'($signed(c.emit_y));
                p[2] = 0;
                age_n = 0;
                v[0] = longint'(da - 15) * ONE_Q16;
                v[1] = longint'(db - 11) * ONE_Q16;
                v[2] = longint'(dc - 15) * ONE_Q16;
                resp = 1'b1;
            end
            // Move with the old velocity, then apply gravity to Y
            for (int k = 0; k < 3; k++) begin
                p[k] = clamp32(p[k] + scale_by_dt(v[k], c.dt));
            end
            v[1] = clamp32(v[1] + scale_by_dt(gravity_q, c.dt));
            // Bounce where the sphere reaches past a wall
            if (p[0] - radius_q < x_low_q || p[0] + radius_q > x_high_q) begin
                v[0] = clamp32(-v[0]);
            end
            if (p[1] - radius_q < y_low_q || p[1] + radius_q > y_high_q) begin
                v[1] = clamp32(-v[1]);
            end
        end

        for (int k = 0; k < 3; k++) begin
            pos_mem[s][k] = p[k][31:0];
            vel_mem[s][k] = v[k][31:0];
        end
        age_mem[s] = age_n[23:0];
        life_mem[s] = life_n[16:0];
        hue_mem[s] = h;

        r.slot = c.slot;
        r.pos_x = p[0][31:0];
        r.pos_y = p[1][31:0];
        r.pos_z = p[2][31:0];
        r.age = age_n[23:0];
        r.life = life_n[16:0];
        r.hue = h;
        r.respawned = resp;
        return r;
    endfunction

    function automatic t_particle_cmd word_of(
        input logic        func,
        input logic [9:0]  slot,
        input logic [15:0] dt,
        input logic [31:0] emit_x,
        input logic [31:0] emit_y,
        input logic [5:0]  draw_a,
        input logic [5:0]  draw_b,
        input logic [5:0]  draw_c,
        input logic [3:0]  tenths,
        input logic        hue
    );
        t_particle_cmd c;
        c.func = func;
        c.slot = slot;
        c.dt = dt;
        c.emit_x = emit_x;
        c.emit_y = emit_y;
        c.draw_a = draw_a;
        c.draw_b = draw_b;
        c.draw_c = draw_c;
        c.tenths = tenths;
        c.hue = hue;
        return c;
    endfunction

    // Drive one word after a random gap (none in the steady stretch), hold it until
    // accepted, then record the result it must cause. Valid stays high into the next call.
    task automatic send_word(input t_particle_cmd c);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 13) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func = c.func;
        i_slot = c.slot;
        i_time_delta = c.dt;
        i_emit_x = c.emit_x;
        i_emit_y = c.emit_y;
        i_draw_a = c.draw_a;
        i_draw_b = c.draw_b;
        i_draw_c = c.draw_c;
        i_life_tenths = c.tenths;
        i_hue_pick = c.hue;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_states.insert(pending_states.size(), advance_particle(c));
        if (c.func == peu_pkg::FUNC_LOAD) begin
            if (!slot_loaded[c.slot]) begin
                slot_loaded[c.slot] = 1'b1;
                loaded_slots.insert(loaded_slots.size(), 32'(c.slot));
            end
            recent_slots.insert(recent_slots.size(), 32'(c.slot));
            if (recent_slots.size() > 6) begin
                void'(recent_slots.pop_front());
            end
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_states.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready; update shadow
    task automatic write_register(input peu_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (idx)
            peu_pkg::REG_GRAVITY:    gravity_q = longint'($signed(value[23:0]));
            peu_pkg::REG_RADIUS:     radius_q = longint'({1'b0, value[20:0]});
            peu_pkg::REG_BOX_X_LOW:  x_low_q = longint'($signed(value[23:0]));
            peu_pkg::REG_BOX_X_HIGH: x_high_q = longint'($signed(value[23:0]));
            peu_pkg::REG_BOX_Y_LOW:  y_low_q = longint'($signed(value[23:0]));
            peu_pkg::REG_BOX_Y_HIGH: y_high_q = longint'($signed(value[23:0]));
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_reset();
        gravity_q = longint'($signed(peu_pkg::RST_GRAVITY));
        radius_q = longint'({1'b0, peu_pkg::RST_RADIUS});
        x_low_q = longint'($signed(peu_pkg::RST_BOX_X_LOW));
        x_high_q = longint'($signed(peu_pkg::RST_BOX_X_HIGH));
        y_low_q = longint'($signed(peu_pkg::RST_BOX_Y_LOW));
        y_high_q = longint'($signed(peu_pkg::RST_BOX_Y_HIGH));
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // Loads at both ends of the slot range, every life setting class
    // (plain, top of range, saturated) and draws at both ends
    task automatic test_load_extremes();
        send_word(word_of(peu_pkg::FUNC_LOAD, 10'h000, 16'h0000, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_LOAD, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 4'd9, 1'b1));
        send_word(word_of(peu_pkg::FUNC_LOAD, 10'h155, 16'h5555, 32'h5555_5555,
                          32'hAAAA_AAAA, 6'd49, 6'd26, 6'd0, 4'd15, 1'b1));
        send_word(word_of(peu_pkg::FUNC_LOAD, 10'h2AA, 16'hAAAA, 32'hAAAA_AAAA,
                          32'h5555_5555, 6'd30, 6'd59, 6'd60, 4'd10, 1'b0));
    endtask

    // Steps covering zero dt, age equal to life (no respawn), respawn with
    // draws beyond 29, saturation of positions at both rails, the saturated
    // life, and back-to-back reuse of one slot
    task automatic test_step_corners();
        // slot 0: life 1.0
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h000, 16'h0000, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h000, 16'hFFFF, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h000, 16'h0001, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h000, 16'h0001,
                          peu_pkg::S32_MIN, peu_pkg::S32_MAX,
                          6'd0, 6'd63, 6'd59, 4'd15, 1'b1));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h000, 16'hFFFF,
                          peu_pkg::S32_MIN, peu_pkg::S32_MAX,
                          6'd0, 6'd63, 6'd59, 4'd15, 1'b1));
        // slot 1023: respawn at the opposite rails
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h3FF, 16'hFFFF, 32'h0, 32'h0,
                          6'd1, 6'd1, 6'd1, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h3FF, 16'hFFFF,
                          peu_pkg::S32_MAX, peu_pkg::S32_MIN,
                          6'd59, 6'd0, 6'd29, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h3FF, 16'h8000,
                          peu_pkg::S32_MAX, peu_pkg::S32_MIN,
                          6'd59, 6'd0, 6'd29, 4'd0, 1'b0));
        // slot 0x155: saturated life, age reaches it exactly, then respawn
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h155, 16'hFFFF, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h155, 16'hFFFF, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h155, 16'h0001, 32'h0, 32'h0,
                          6'd0, 6'd0, 6'd0, 4'd0, 1'b0));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h155, 16'hFFFF, 32'h0005_0000,
                          32'hFFFB_0000, 6'd44, 6'd41, 6'd15, 4'd0, 1'b0));
        // slot 0x2AA: alternating bit patterns
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h2AA, 16'h5555, 32'h5555_5555,
                          32'hAAAA_AAAA, 6'd21, 6'd42, 6'd63, 4'd5, 1'b1));
        send_word(word_of(peu_pkg::FUNC_STEP, 10'h2AA, 16'hAAAA, 32'hAAAA_AAAA,
                          32'h5555_5555, 6'd42, 6'd21, 6'd0, 4'd10, 1'b0));
    endtask

    // Mostly steps, chiefly on recently loaded slots, so particles live long enough
    // to bounce, respawn and saturate; the rest are fresh loads anywhere in the table
    task automatic issue_random_words(input int unsigned count);
        t_particle_cmd c;
        for (int unsigned n = 0; n < count; n++) begin
            c.func = (loaded_slots.size() == 0 || $urandom_range(99) < 18)
                     ? peu_pkg::FUNC_LOAD : peu_pkg::FUNC_STEP;
            if (c.func == peu_pkg::FUNC_LOAD) begin
                c.slot = 10'($urandom_range(SLOTS - 1));
            end else if (recent_slots.size() != 0 && $urandom_range(99) < 70) begin
                c.slot = 10'(recent_slots[$urandom_range(recent_slots.size() - 1)]);
            end else begin
                c.slot = 10'(loaded_slots[$urandom_range(loaded_slots.size() - 1)]);
            end
            case ($urandom_range(3))
                0: c.dt = 16'($urandom_range(65535));
                1: c.dt = 16'($urandom_range(255));
                2: c.dt = 16'($urandom_range(65535, 49152));
                default: c.dt = 16'($urandom_range(16383, 4096));
            endcase
            if ($urandom_range(1) == 0) begin
                c.emit_x = $urandom();
                c.emit_y = $urandom();
            end else begin
                // Emitter inside a box of about +-20.0
                c.emit_x = $urandom_range(2621440) - 1310720;
                c.emit_y = $urandom_range(2621440) - 1310720;
            end
            c.draw_a = 6'($urandom_range(63));
            c.draw_b = 6'($urandom_range(63));
            c.draw_c = 6'($urandom_range(63));
            c.tenths = 4'($urandom_range(15));
            c.hue = 1'($urandom_range(1));
            send_word(c);
        end
    endtask

    // Run phases of random traffic under various register settings; the first keeps
    // the reset values, the last writes them back, one runs without any idling
    task automatic test_register_settings();
        logic [31:0] g;
        logic [31:0] rad;
        logic [31:0] xl;
        logic [31:0] xh;
        logic [31:0] yl;
        logic [31:0] yh;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                1: begin
                    // strongest downward gravity, zero radius, widest box
                    g = 32'hFF80_0000;
                    rad = 32'd0;
                    xl = 32'hFF80_0000;
                    xh = 32'h007F_FFFF;
                    yl = 32'hFF80_0000;
                    yh = 32'h007F_FFFF;
                end
                2: begin
                    // strongest upward gravity, radius of 16.0, inverted box
                    g = 32'h007F_FFFF;
                    rad = 32'd1048576;
                    xl = 32'h007F_FFFF;
                    xh = 32'hFF80_0000;
                    yl = 32'h007F_FFFF;
                    yh = 32'hFF80_0000;
                end
                3: begin
                    g = $urandom_range(16777215) - 8388608;
                    rad = $urandom_range(1048576);
                    xl = $urandom_range(16777215) - 8388608;
                    xh = $urandom_range(16777215) - 8388608;
                    yl = $urandom_range(16777215) - 8388608;
                    yh = $urandom_range(16777215) - 8388608;
                end
                4: begin
                    // moderate gravity, small radius, box of 1.0 to 20.0 each side
                    g = $urandom_range(2621440) - 1310720;
                    rad = $urandom_range(65536);
                    xl = -$urandom_range(1310720, 65536);
                    xh = $urandom_range(1310720, 65536);
                    yl = -$urandom_range(1310720, 65536);
                    yh = $urandom_range(1310720, 65536);
                end
                default: begin
                    g = {{8{peu_pkg::RST_GRAVITY[23]}}, peu_pkg::RST_GRAVITY};
                    rad = {11'd0, peu_pkg::RST_RADIUS};
                    xl = {{8{peu_pkg::RST_BOX_X_LOW[23]}}, peu_pkg::RST_BOX_X_LOW};
                    xh = {{8{peu_pkg::RST_BOX_X_HIGH[23]}}, peu_pkg::RST_BOX_X_HIGH};
                    yl = {{8{peu_pkg::RST_BOX_Y_LOW[23]}}, peu_pkg::RST_BOX_Y_LOW};
                    yh = {{8{peu_pkg::RST_BOX_Y_HIGH[23]}}, peu_pkg::RST_BOX_Y_HIGH};
                end
            endcase
            if (phase != 0) begin
                write_register(peu_pkg::REG_GRAVITY, g);
                write_register(peu_pkg::REG_RADIUS, rad);
                write_register(peu_pkg::REG_BOX_X_LOW, xl);
                write_register(peu_pkg::REG_BOX_X_HIGH, xh);
                write_register(peu_pkg::REG_BOX_Y_LOW, yl);
                write_register(peu_pkg::REG_BOX_Y_HIGH, yh);
            end
            steady = (phase == 3);
            issue_random_words(RANDOM_WORDS / PHASES);
            steady = 1'b0;
        end
    endtask

    // Receiver: stall at random, except during the steady stretch
    always @(negedge i_clk) begin
        i_ready = steady || ($urandom_range(99) >= 13);
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        end
    endtask

    // Compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_states.size() == 0) begin
                error_count++;
                $display("%0t: result word for slot %h with none expected",
                         $time, o_slot_out);
            end else begin
                oldest = pending_states.pop_front();
                check_field("slot_out", 32'(oldest.slot), 32'(o_slot_out));
                check_field("pos_x", oldest.pos_x, o_pos_x);
                check_field("pos_y", oldest.pos_y, o_pos_y);
                check_field("pos_z", oldest.pos_z, o_pos_z);
                check_field("age_out", 32'(oldest.age), 32'(o_age_out));
                check_field("life_out", 32'(oldest.life), 32'(o_life_out));
                check_field("hue_out", 32'(oldest.hue), 32'(o_hue_out));
                check_field("respawned", 32'(oldest.respawned), 32'(o_respawned));
            end
        end
    end

    // Hard stop if the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        apply_reset();
        test_load_extremes();
        test_step_corners();
        test_register_settings();
        drain_results();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/peu_pkg.sv
sv/particle_euler_update.sv
sv/peu_chk.sv
sim/particle_euler_update_test.sv
